FILE: rtl/bpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types and constants for the byte-rate paced packet FIFO.
// ----------------------------------------------------------------------------
package bpr_pkg;

	localparam int HANDLE_W   = 16;
	localparam int LENGTH_W   = 16;
	localparam int MARGIN_W   = 9;
	localparam int RATE_W     = 32;
	localparam int WIN_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// window_bytes * 1000 fits in 42 bits
	localparam int MS_PER_SEC_W = 10;
	localparam logic [MS_PER_SEC_W-1:0] MS_PER_SEC = 10'd1000;
	localparam int DIVIDEND_W   = WIN_W + MS_PER_SEC_W;
	localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);

	typedef enum logic [1:0] {
		ACT_ARRIVAL = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_DRAIN   = 2'd2,
		ACT_FLUSH   = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MARGIN = 2'd0,
		CFG_LIMIT  = 2'd1,
		CFG_RATE   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] margin;
		logic [MARGIN_W-1:0] limit;
		logic [RATE_W-1:0]   rate;
	} cfg_t;

	typedef struct packed {
		action_t             action;
		logic [HANDLE_W-1:0] handle;
		logic [LENGTH_W-1:0] length;
	} item_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [RATE_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACT,
		ST_PASS,
		ST_LOAD,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/bpr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_if
// Channel interfaces: input items, result words and configuration writes.
// ----------------------------------------------------------------------------
interface bpr_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] packet_handle;
	logic [15:0] packet_length;

	modport source (output valid, action, packet_handle, packet_length, input ready);
	modport sink   (input valid, action, packet_handle, packet_length, output ready);
endinterface

interface bpr_result_if #(
	parameter int CNT_W = 9
);
	logic             valid;
	logic             ready;
	logic             released;
	logic [15:0]      out_handle;
	logic [15:0]      out_length;
	logic             hold_off;
	logic [CNT_W-1:0] queue_count;

	modport source (output valid, released, out_handle, out_length, hold_off, queue_count,
		input ready);
	modport sink   (input valid, released, out_handle, out_length, hold_off, queue_count,
		output ready);
endinterface

interface bpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/byte_rate_paced_packet_fifo_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_rate_paced_packet_fifo_unit
// Packet queue released oldest first under a byte-rate pacing window.
// ----------------------------------------------------------------------------
// Each input word (arrival, millisecond tick, start drain, flush) yields
// exactly one result word giving any released packet, the hold-off flag and
// the queue depth. A two-word input queue lets the sender run ahead of the
// engine, and the result register lets the next word start while a result
// waits. A paced release runs the 42-step restoring divider that forms
// bytes*1000/rate; a word with no release, or a release with pacing off,
// skips the divider.
// Configuration writes take effect at once and are always accepted; the
// result port's queue_count is 9 bits wide, the depth taken modulo 512.
module byte_rate_paced_packet_fifo_unit
	import bpr_pkg::*;
#(
	parameter int QUEUE_DEPTH       = 256,
	parameter int WINDOW_RESTART_MS = 500
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bpr_item_if.sink     item,
	bpr_result_if.source result,
	bpr_cfg_if.sink      cfg
);

	cfg_t  cfg_q;
	item_t fe_item;
	logic  fe_valid;
	logic  fe_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin <= MARGIN_W'(0);
			cfg_q.limit  <= MARGIN_W'(256);
			cfg_q.rate   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MARGIN: cfg_q.margin <= cfg.data[MARGIN_W-1:0];
				CFG_LIMIT:  cfg_q.limit  <= cfg.data[MARGIN_W-1:0];
				CFG_RATE:   cfg_q.rate   <= cfg.data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	bpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.fe_item  (fe_item),
		.fe_valid (fe_valid),
		.fe_ready (fe_ready)
	);

	bpr_back #(
		.QUEUE_DEPTH       (QUEUE_DEPTH),
		.WINDOW_RESTART_MS (WINDOW_RESTART_MS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.fe_item  (fe_item),
		.fe_valid (fe_valid),
		.fe_ready (fe_ready),
		.result   (result)
	);

endmodule
`default_nettype wire

FILE: rtl/bpr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_front
// Accepts input words, decodes the action and queues them for the engine.
// ----------------------------------------------------------------------------
module bpr_front
	import bpr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	bpr_item_if.sink   item,
	output item_t      fe_item,
	output logic       fe_valid,
	input  wire logic  fe_ready
);

	item_t      entry_q [2];
	logic       wr_idx_q;
	logic       rd_idx_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	item_t      decoded;

	always_comb begin
		decoded.action = action_t'(item.action);
		decoded.handle = item.packet_handle;
		decoded.length = item.packet_length;
	end

	assign item.ready = (count_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign fe_valid   = (count_q != 2'd0);
	assign pop        = fe_valid && fe_ready;
	assign fe_item    = entry_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_idx_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_idx_q <= ~wr_idx_q;
			end
			if (pop) begin
				rd_idx_q <= ~rd_idx_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bpr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpr_div
	import bpr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  div_req_t   req,
	output div_rsp_t   rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0]     divisor_q;
	logic [RATE_W-1:0]     rem_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [RATE_W:0]       rem_sh;
	logic                  ge;

	assign rem_sh = {rem_q, dq_q[DIVIDEND_W-1]};
	assign ge     = (rem_sh >= {1'b0, divisor_q});

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= '0;
			dq_q      <= req.dividend;
		end else if (busy_q) begin
			// shift dividend bits out, quotient bits in
			rem_q <= ge ? RATE_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[RATE_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bpr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpr_back
// Executes queued words: packet store, release pass, pacing window and
// the result register.
// ----------------------------------------------------------------------------
module bpr_back
	import bpr_pkg::*;
#(
	parameter int QUEUE_DEPTH       = 256,
	parameter int WINDOW_RESTART_MS = 500
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	input  item_t      fe_item,
	input  wire logic  fe_valid,
	output logic       fe_ready,
	bpr_result_if.source result
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > MARGIN_W) ? CNT_W : MARGIN_W;
	localparam int ENT_W = HANDLE_W + LENGTH_W;

	state_t state_q, state_d;

	// packet store
	logic [ENT_W-1:0] mem [QUEUE_DEPTH];
	logic [ENT_W-1:0] rdata_q;
	logic             mem_we;
	logic             mem_re;

	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] held_q;
	logic [WIN_W-1:0] win_bytes_q;
	logic [WIN_W-1:0] win_ms_q;
	logic [WIN_W-1:0] hold_q;
	logic             drain_q;
	logic             res_valid_q;

	item_t             item_q;
	logic              rel_q;
	logic              pass_q;
	logic              idle_q;
	logic [WIN_W-1:0]  allowed_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic [LENGTH_W-1:0] res_length_q;
	logic              res_rel_q;
	logic              res_hold_q;
	logic [MARGIN_W-1:0] res_count_q;

	logic [CMP_W-1:0]  depth_ext;
	logic [CMP_W-1:0]  margin_ext;
	logic [CMP_W-1:0]  limit_ext;
	logic              not_full;
	logic              rel_go;
	logic              res_load;
	logic [WIN_W:0]    bytes_sum;
	logic [DIVIDEND_W-1:0] bytes_ext;
	logic              win_over;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign depth_ext  = CMP_W'(held_q);
	assign margin_ext = CMP_W'(cfg.margin);
	assign limit_ext  = CMP_W'(cfg.limit);
	assign not_full   = (held_q < CNT_W'(QUEUE_DEPTH));
	assign rel_go     = (hold_q == '0) && (held_q != '0) &&
		((depth_ext > margin_ext) || drain_q);
	assign bytes_sum  = {1'b0, win_bytes_q} + (WIN_W + 1)'(rdata_q[LENGTH_W-1:0]);
	assign bytes_ext  = DIVIDEND_W'(win_bytes_q);
	assign win_over   = (win_ms_q > WIN_W'(WINDOW_RESTART_MS));

	bpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (fe_valid) state_d = ST_ACT;
			ST_ACT:  state_d = ST_PASS;
			ST_PASS: state_d = rel_go ? ST_LOAD : ST_FIN;
			ST_LOAD: state_d = (cfg.rate != '0) ? ST_MUL : ST_FIN;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (div_rsp.done) state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (!res_valid_q || result.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		fe_ready         = 1'b0;
		mem_we           = 1'b0;
		mem_re           = 1'b0;
		res_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = bytes_ext * DIVIDEND_W'(MS_PER_SEC);
		div_req.divisor  = cfg.rate;
		unique case (state_q)
			ST_IDLE: fe_ready = 1'b1;
			ST_ACT:  mem_we = (item_q.action == ACT_ARRIVAL) && not_full;
			ST_PASS: mem_re = rel_go;
			ST_MUL:  div_req.start = 1'b1;
			ST_OUT:  res_load = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= {item_q.handle, item_q.length};
		end
		if (mem_re) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (fe_valid && fe_ready) begin
			item_q <= fe_item;
		end
		unique case (state_q)
			ST_ACT: begin
				rel_q     <= 1'b0;
				allowed_q <= '0;
			end
			ST_PASS: begin
				pass_q <= (hold_q == '0);
				idle_q <= (depth_ext <= margin_ext);
				rel_q  <= rel_go;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					allowed_q <= (div_rsp.quotient[DIVIDEND_W-1:WIN_W] != '0) ?
						'1 : div_rsp.quotient[WIN_W-1:0];
				end
			end
			default: ;
		endcase
		if (res_load) begin
			res_rel_q    <= rel_q;
			res_handle_q <= rel_q ? rdata_q[ENT_W-1:LENGTH_W] : '0;
			res_length_q <= rel_q ? rdata_q[LENGTH_W-1:0] : '0;
			res_hold_q   <= (depth_ext > limit_ext);
			res_count_q  <= MARGIN_W'(held_q);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			held_q      <= '0;
			win_bytes_q <= '0;
			win_ms_q    <= '0;
			hold_q      <= '0;
			drain_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_load || (res_valid_q && !result.ready);
			unique case (state_q)
				ST_ACT: begin
					unique case (item_q.action)
						ACT_ARRIVAL: begin
							if (not_full) begin
								wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ?
									'0 : wr_ptr_q + PTR_W'(1);
								held_q   <= held_q + CNT_W'(1);
							end
						end
						ACT_TICK: begin
							if (win_ms_q != '1) begin
								win_ms_q <= win_ms_q + WIN_W'(1);
							end
							if (hold_q != '0) begin
								hold_q <= hold_q - WIN_W'(1);
							end
						end
						ACT_DRAIN: drain_q <= 1'b1;
						ACT_FLUSH: begin
							rd_ptr_q <= '0;
							wr_ptr_q <= '0;
							held_q   <= '0;
						end
						default: ;
					endcase
				end
				ST_PASS: begin
					if (rel_go) begin
						rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ?
							'0 : rd_ptr_q + PTR_W'(1);
						held_q   <= held_q - CNT_W'(1);
					end
				end
				ST_LOAD: begin
					// saturate the window byte total
					win_bytes_q <= bytes_sum[WIN_W] ? '1 : bytes_sum[WIN_W-1:0];
				end
				ST_FIN: begin
					if (rel_q && (allowed_q > win_ms_q)) begin
						hold_q <= allowed_q - win_ms_q;
					end
					if ((rel_q && win_over) || (pass_q && idle_q)) begin
						win_bytes_q <= '0;
						win_ms_q    <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid       = res_valid_q;
	assign result.released    = res_rel_q;
	assign result.out_handle  = res_handle_q;
	assign result.out_length  = res_length_q;
	assign result.hold_off    = res_hold_q;
	assign result.queue_count = res_count_q;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte-rate paced packet FIFO.
// ----------------------------------------------------------------------------
// Words go in over the item channel with random gaps. A scoreboard keeps its
// own copy of the queue, the drain flag and the pacing window, forms the
// expected result word for every accepted item, and checks the result words
// in order, field by field. Registers are rewritten between phases once every
// result is back. A final phase drives the pacing hold to saturation and
// overfills the queue.
// ----------------------------------------------------------------------------
class pacer_scoreboard #(int unsigned SLOTS = 256, int unsigned RESTART_MS = 500);

	typedef struct packed {
		logic        released;
		logic [15:0] handle;
		logic [15:0] length;
		logic        hold_off;
		logic [8:0]  count;
	} outcome_t;

	logic [15:0] handle_mem [SLOTS];
	logic [15:0] length_mem [SLOTS];
	int unsigned rd_ptr;
	int unsigned wr_ptr;
	int unsigned held;
	logic [31:0] win_bytes;
	logic [31:0] win_ms;
	logic [31:0] hold_left;
	bit          draining;
	logic [8:0]  margin;
	logic [8:0]  limit;
	logic [31:0] rate;
	outcome_t    pending_results [$];
	int          errors;

	function new();
		rd_ptr    = 0;
		wr_ptr    = 0;
		held      = 0;
		win_bytes = '0;
		win_ms    = '0;
		hold_left = '0;
		draining  = 1'b0;
		margin    = 9'd0;
		limit     = 9'd256;
		rate      = '0;
		errors    = 0;
	endfunction

	function int unsigned wrap_next(int unsigned p);
		return (p + 1 >= SLOTS) ? 0 : p + 1;
	endfunction

	function int pending();
		return pending_results.size();
	endfunction

	function void set_reg(bpr_pkg::cfg_idx_t idx, logic [31:0] val);
		case (idx)
			bpr_pkg::CFG_MARGIN: margin = val[8:0];
			bpr_pkg::CFG_LIMIT:  limit  = val[8:0];
			bpr_pkg::CFG_RATE:   rate   = val;
			default: ;
		endcase
	endfunction

	function void predict_item(bpr_pkg::action_t act, logic [15:0] h, logic [15:0] len);
		outcome_t    r;
		int unsigned depth;
		logic [32:0] sum;
		logic [63:0] allowed;
		r = '0;
		case (act)
			bpr_pkg::ACT_ARRIVAL: begin
				// drop the word when the queue is full
				if (held < SLOTS) begin
					handle_mem[wr_ptr] = h;
					length_mem[wr_ptr] = len;
					wr_ptr = wrap_next(wr_ptr);
					held++;
				end
			end
			bpr_pkg::ACT_TICK: begin
				if (win_ms != 32'hFFFF_FFFF)
					win_ms++;
				if (hold_left != 0)
					hold_left--;
			end
			bpr_pkg::ACT_DRAIN: draining = 1'b1;
			default: begin
				rd_ptr = 0;
				wr_ptr = 0;
				held   = 0;
			end
		endcase

		if (hold_left == 0) begin
			depth = held;
			if (depth != 0 && (depth > margin || draining)) begin
				r.released = 1'b1;
				r.handle   = handle_mem[rd_ptr];
				r.length   = length_mem[rd_ptr];
				rd_ptr = wrap_next(rd_ptr);
				held--;
				sum = {1'b0, win_bytes} + {17'd0, r.length};
				win_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				if (rate != 0) begin
					allowed = ({32'd0, win_bytes} * 64'd1000) / {32'd0, rate};
					if (allowed > 64'h0000_0000_FFFF_FFFF)
						allowed = 64'h0000_0000_FFFF_FFFF;
				end else begin
					allowed = '0;
				end
				// hold for the part of the budget not yet covered by elapsed ms
				if (allowed[31:0] > win_ms)
					hold_left = allowed[31:0] - win_ms;
				if (win_ms > RESTART_MS) begin
					win_bytes = '0;
					win_ms    = '0;
				end
			end
			// idle pass restarts the window
			if (depth <= margin) begin
				win_bytes = '0;
				win_ms    = '0;
			end
		end

		r.hold_off = (held > limit);
		r.count    = held[8:0];
		pending_results.push_back(r);
	endfunction

	function void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(logic rel, logic [15:0] h, logic [15:0] len, logic ho,
		logic [8:0] cnt);
		outcome_t want;
		if (pending_results.size() == 0) begin
			$error("result word with no item outstanding");
			errors++;
			return;
		end
		want = pending_results.pop_front();
		check_field("released", want.released, rel);
		check_field("out_handle", want.handle, h);
		check_field("out_length", want.length, len);
		check_field("hold_off", want.hold_off, ho);
		check_field("queue_count", want.count, cnt);
	endfunction

endclass

module testbench;
	import bpr_pkg::*;

	localparam int QUEUE_DEPTH  = 256;
	localparam int WINDOW_MS    = 500;
	localparam int SETTLE_WAIT  = 100;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;

	bpr_item_if                item_ch ();
	bpr_result_if #(.CNT_W(9)) result_ch ();
	bpr_cfg_if                 cfg_ch ();

	pacer_scoreboard #(QUEUE_DEPTH, WINDOW_MS) sb;

	byte_rate_paced_packet_fifo_unit #(
		.QUEUE_DEPTH       (QUEUE_DEPTH),
		.WINDOW_RESTART_MS (WINDOW_MS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("byte_rate_paced_packet_fifo_unit verification failed");
		$finish;
	end

	// result side: random back-pressure
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.released, result_ch.out_handle, result_ch.out_length,
				result_ch.hold_off, result_ch.queue_count);
	end

	function automatic void set_idling(int mode);
		case (mode)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 77;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 77;
			end
			default: begin
				send_idle_pct  = 22;
				recv_stall_pct = 22;
			end
		endcase
	endfunction

	// keep valid high across back-to-back words; lower it only for a gap
	task automatic send_item(input action_t act, input logic [15:0] h, input logic [15:0] len);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.action        <= act;
		item_ch.packet_handle <= h;
		item_ch.packet_length <= len;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		sb.predict_item(act, h, len);
	endtask

	task automatic send_random_item();
		int          pick;
		int          sel;
		action_t     act;
		logic [15:0] len;
		pick = $urandom_range(0, 99);
		sel  = $urandom_range(0, 9);
		if (sel < 6)
			len = 16'($urandom_range(0, 1500));
		else if (sel < 8)
			len = 16'($urandom);
		else if (sel == 8)
			len = 16'h0000;
		else
			len = 16'hFFFF;
		if (pick < 55)
			act = ACT_ARRIVAL;
		else if (pick < 91)
			act = ACT_TICK;
		else if (pick < 95)
			act = ACT_DRAIN;
		else
			act = ACT_FLUSH;
		send_item(act, 16'($urandom), len);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// tick out any pacing hold, then flush so an idle pass restarts the window
	task automatic quiesce_pacing();
		while (sb.hold_left != 0)
			send_item(ACT_TICK, 16'($urandom), 16'($urandom));
		send_item(ACT_FLUSH, 16'($urandom), 16'($urandom));
	endtask

	task automatic configure(input logic [31:0] m, input logic [31:0] l, input logic [31:0] r);
		cfg_idx_t    idx [3];
		logic [31:0] val [3];
		idx = '{CFG_MARGIN, CFG_LIMIT, CFG_RATE};
		val = '{m, l, r};
		for (int k = 0; k < 3; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[k];
			cfg_ch.data  <= val[k];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			sb.set_reg(idx[k], val[k]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] phase_margin;
		logic [31:0] phase_limit;
		logic [31:0] phase_rate;

		sb = new();
		set_idling(0);
		arst_n                <= 1'b0;
		item_ch.valid         <= 1'b0;
		item_ch.action        <= ACT_ARRIVAL;
		item_ch.packet_handle <= '0;
		item_ch.packet_length <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= CFG_MARGIN;
		cfg_ch.data           <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// margin gating, hold-off, flush, then drain mode
		configure(32'd2, 32'd1, 32'd0);
		send_item(ACT_TICK, 16'h0000, 16'h0000);
		send_item(ACT_ARRIVAL, 16'h0000, 16'h0000);
		send_item(ACT_ARRIVAL, 16'hFFFF, 16'hFFFF);
		send_item(ACT_ARRIVAL, 16'hA5A5, 16'h5A5A);
		send_item(ACT_ARRIVAL, 16'h5A5A, 16'hA5A5);
		send_item(ACT_FLUSH, 16'hFFFF, 16'hFFFF);
		send_item(ACT_ARRIVAL, 16'h1234, 16'h0001);
		send_item(ACT_TICK, 16'h0000, 16'h0000);
		send_item(ACT_DRAIN, 16'h0000, 16'h0000);
		send_item(ACT_DRAIN, 16'h0000, 16'h0000);
		send_item(ACT_ARRIVAL, 16'h4321, 16'h0010);
		send_item(ACT_FLUSH, 16'h0000, 16'h0000);
		send_item(ACT_ARRIVAL, 16'h00FF, 16'hFF00);
		quiesce_pacing();
		wait_drained();

		// registers above range, one byte per ms pacing
		configure(32'd511, 32'd511, 32'd1000);
		send_item(ACT_ARRIVAL, 16'h0001, 16'h0003);
		send_item(ACT_ARRIVAL, 16'h0002, 16'h0004);
		send_item(ACT_TICK, 16'h0000, 16'h0000);
		send_item(ACT_TICK, 16'h0000, 16'h0000);
		send_item(ACT_TICK, 16'h0000, 16'h0000);
		quiesce_pacing();
		wait_drained();

		configure(32'd0, 32'd0, 32'hFFFF_FFFF);
		send_item(ACT_ARRIVAL, 16'hFFFF, 16'hFFFF);
		send_item(ACT_ARRIVAL, 16'h8000, 16'h8000);
		quiesce_pacing();
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			set_idling(p % 4);
			if (p == 0)
				phase_margin = 32'd0;
			else if (p == 1)
				phase_margin = 32'd511;
			else if (p == 2)
				phase_margin = 32'd256;
			else
				phase_margin = $urandom_range(0, (p == 7) ? 511 : 8);
			if (p == 0)
				phase_limit = 32'd0;
			else if (p == 1)
				phase_limit = 32'd511;
			else if (p == 2)
				phase_limit = 32'd256;
			else
				phase_limit = $urandom_range(0, 256);
			if (p == 0)
				phase_rate = 32'd0;
			else if (p == 1)
				phase_rate = 32'hFFFF_FFFF;
			else
				phase_rate = $urandom_range(200_000, 8_000_000);
			configure(phase_margin, phase_limit, phase_rate);
			repeat (100) send_random_item();
			quiesce_pacing();
			wait_drained();
		end

		// build a large window unpaced, then pace at one byte per second
		set_idling(3);
		configure(32'd0, 32'd511, 32'd0);
		repeat (70) send_item(ACT_ARRIVAL, 16'($urandom), 16'hFFFF);
		wait_drained();
		configure(32'd0, 32'd200, 32'd1);
		set_idling(1);
		repeat (270) send_item(ACT_ARRIVAL, 16'($urandom), 16'($urandom));
		set_idling(2);
		repeat (5) send_item(ACT_TICK, 16'($urandom), 16'($urandom));
		send_item(ACT_FLUSH, 16'($urandom), 16'($urandom));
		repeat (20) send_random_item();
		send_item(ACT_DRAIN, 16'($urandom), 16'($urandom));
		wait_drained();
		repeat (SETTLE_WAIT) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("byte_rate_paced_packet_fifo_unit verification clean");
		else
			$display("byte_rate_paced_packet_fifo_unit verification failed");
		$finish;
	end

endmodule
`default_nettype wire
